### hdl/dts_pkg.sv
package dts_pkg;

	localparam int LINE_BITS = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int MAX_RESULTS = 3;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_DIGITS  = 3'd2,
		MODE_COLON   = 3'd3,
		MODE_STRING  = 3'd4,
		MODE_BSLASH  = 3'd5,
		MODE_COMMENT = 3'd6
	} scan_mode_t;

	typedef enum logic [3:0] {
		TK_COMMA     = 4'd0,
		TK_PERIOD    = 4'd1,
		TK_QMARK     = 4'd2,
		TK_LPAREN    = 4'd3,
		TK_RPAREN    = 4'd4,
		TK_COLON     = 4'd5,
		TK_COLONDASH = 4'd6,
		TK_SCHEMES   = 4'd7,
		TK_FACTS     = 4'd8,
		TK_RULES     = 4'd9,
		TK_QUERIES   = 4'd10,
		TK_ID        = 4'd11,
		TK_STRING    = 4'd12,
		TK_ERROR     = 4'd13,
		TK_ENDFILE   = 4'd14
	} tok_kind_t;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	localparam logic REC_CHAR  = 1'b0;
	localparam logic REC_TOKEN = 1'b1;

	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_HASH    = 8'd35;
	localparam logic [7:0] CH_QUOTE   = 8'd39;
	localparam logic [7:0] CH_LPAREN  = 8'd40;
	localparam logic [7:0] CH_RPAREN  = 8'd41;
	localparam logic [7:0] CH_COMMA   = 8'd44;
	localparam logic [7:0] CH_DASH    = 8'd45;
	localparam logic [7:0] CH_PERIOD  = 8'd46;
	localparam logic [7:0] CH_COLON   = 8'd58;
	localparam logic [7:0] CH_QMARK   = 8'd63;
	localparam logic [7:0] CH_BSLASH  = 8'd92;

	localparam logic [7:0] KW_TEXT [4][8] = '{
		'{"S", "c", "h", "e", "m", "e", "s", 8'h00},
		'{"F", "a", "c", "t", "s", 8'h00, 8'h00, 8'h00},
		'{"R", "u", "l", "e", "s", 8'h00, 8'h00, 8'h00},
		'{"Q", "u", "e", "r", "i", "e", "s", 8'h00}
	};
	localparam logic [3:0] KW_LEN [4] = '{4'd7, 4'd5, 4'd5, 4'd7};
	localparam tok_kind_t KW_KIND [4] = '{TK_SCHEMES, TK_FACTS, TK_RULES, TK_QUERIES};

	typedef struct packed {
		logic       operation;
		logic [7:0] char_code;
	} src_item_t;

	typedef struct packed {
		logic        record_kind;
		logic [7:0]  lexeme_char;
		tok_kind_t   token_kind;
		logic [15:0] line_number;
		logic        last;
	} res_item_t;

	// backtick counts as a letter, as does '{'
	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd96 && c <= 8'd123);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'd48 && c <= 8'd57;
	endfunction

	function automatic tok_kind_t punct_kind(input logic [7:0] c);
		tok_kind_t k;
		k = TK_ERROR;
		case (c)
			CH_COMMA:  k = TK_COMMA;
			CH_PERIOD: k = TK_PERIOD;
			CH_QMARK:  k = TK_QMARK;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			default:   k = TK_ERROR;
		endcase
		return k;
	endfunction

	// drop keywords that no longer match at this position
	function automatic logic [3:0] kw_match(input logic [3:0] alive, input logic [3:0] wl,
			input logic [7:0] c);
		logic [3:0] a;
		a = alive;
		for (int k = 0; k < 4; k++) begin
			if (wl >= KW_LEN[k] || KW_TEXT[k][wl[2:0]] != c)
				a[k] = 1'b0;
		end
		return a;
	endfunction

endpackage

### hdl/datalog_token_scanner.sv
// Results of an accepted request are written into a result queue; res shows its head.
// Throughput: one request per cycle while each request yields at most one
// result and res_ready stays high; src_ready drops while the four-entry result
// queue holds more than one result, the queue draining one per cycle on res_ready.
// Reset (arst_n low, asynchronous): scanner idle, line count zero, queue empty.
module datalog_token_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  dts_pkg::src_item_t src_item,
	output logic               res_valid,
	input  logic               res_ready,
	output dts_pkg::res_item_t res_item
);

	localparam logic [dts_pkg::LINE_BITS-1:0] LINE_MAX = {dts_pkg::LINE_BITS{1'b1}};

	dts_pkg::scan_mode_t mode_q, mode_d;
	logic [3:0] alive_q, alive_d;
	logic [3:0] wl_q, wl_d;
	logic [1:0] dash_q, dash_d;
	logic [dts_pkg::LINE_BITS-1:0] line_q, line_d, line_b, ln;
	logic open_q, open_d;

	dts_pkg::res_item_t fifo_q [dts_pkg::FIFO_DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	dts_pkg::res_item_t res [dts_pkg::MAX_RESULTS];
	logic [1:0] nres;
	logic [7:0] c;
	logic taken;
	logic fin_emit;
	dts_pkg::tok_kind_t fin_kind;
	logic accept, pop;

	assign accept    = src_valid && src_ready;
	assign pop       = res_valid && res_ready;
	assign src_ready = cnt_q <= 3'd1;
	assign res_valid = cnt_q != 3'd0;
	assign res_item  = fifo_q[rd_q];

	assign line_b = (line_q != LINE_MAX) ? line_q + 1'b1 : line_q;

	function automatic dts_pkg::res_item_t mk_tok(input dts_pkg::tok_kind_t k,
			input logic [dts_pkg::LINE_BITS-1:0] l);
		dts_pkg::res_item_t r;
		logic [dts_pkg::LINE_BITS-1:0] lc;
		lc = (l > dts_pkg::LINE_BITS'(65535)) ? dts_pkg::LINE_BITS'(65535) : l;
		r.record_kind = dts_pkg::REC_TOKEN;
		r.lexeme_char = 8'd0;
		r.token_kind  = k;
		r.line_number = 16'(lc);
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic dts_pkg::res_item_t mk_char(input logic [7:0] ch);
		dts_pkg::res_item_t r;
		r.record_kind = dts_pkg::REC_CHAR;
		r.lexeme_char = ch;
		r.token_kind  = dts_pkg::TK_COMMA;
		r.line_number = 16'd0;
		r.last        = 1'b0;
		return r;
	endfunction

	// token that closes whatever is open in the current state
	always_comb begin
		fin_emit = 1'b1;
		fin_kind = dts_pkg::TK_ID;
		unique case (mode_q)
			dts_pkg::MODE_WORD: begin
				for (int k = 0; k < 4; k++) begin
					if (alive_q[k] && wl_q == dts_pkg::KW_LEN[k])
						fin_kind = dts_pkg::KW_KIND[k];
				end
			end
			dts_pkg::MODE_DIGITS: fin_kind = dts_pkg::TK_ERROR;
			dts_pkg::MODE_COLON:
				fin_kind = (dash_q == 2'd1) ? dts_pkg::TK_COLONDASH : dts_pkg::TK_COLON;
			dts_pkg::MODE_BSLASH: fin_kind = dts_pkg::TK_ID;
			dts_pkg::MODE_STRING: fin_kind = dts_pkg::TK_ERROR;
			default: fin_emit = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < dts_pkg::MAX_RESULTS; i++)
			res[i] = mk_char(8'd0);
		nres    = 2'd0;
		mode_d  = mode_q;
		alive_d = alive_q;
		wl_d    = wl_q;
		dash_d  = dash_q;
		line_d  = line_q;
		open_d  = open_q;
		taken   = 1'b0;
		c       = src_item.char_code;
		ln      = open_q ? line_q : line_b;

		if (src_item.operation == dts_pkg::OP_EOF) begin
			if (open_q && fin_emit) begin
				res[nres] = mk_tok(fin_kind, line_q);
				nres++;
			end
			res[nres] = mk_tok(dts_pkg::TK_ENDFILE, line_q);
			nres++;
			mode_d  = dts_pkg::MODE_IDLE;
			alive_d = 4'hF;
			wl_d    = 4'd0;
			dash_d  = 2'd0;
			line_d  = '0;
			open_d  = 1'b0;
		end else if (c == dts_pkg::CH_NEWLINE) begin
			line_d = ln;
			if (fin_emit) begin
				res[nres] = mk_tok(fin_kind, ln);
				nres++;
			end
			mode_d = dts_pkg::MODE_IDLE;
			open_d = 1'b0;
		end else begin
			line_d = ln;
			open_d = 1'b1;
			unique case (mode_q)
				dts_pkg::MODE_STRING: begin
					taken = 1'b1;
					if (c == dts_pkg::CH_QUOTE) begin
						res[nres] = mk_tok(dts_pkg::TK_STRING, ln);
						nres++;
						mode_d = dts_pkg::MODE_IDLE;
					end else begin
						res[nres] = mk_char(c);
						nres++;
					end
				end
				dts_pkg::MODE_COMMENT: taken = 1'b1;
				dts_pkg::MODE_WORD: begin
					if (dts_pkg::is_letter(c) || dts_pkg::is_digit(c)) begin
						alive_d = dts_pkg::kw_match(alive_q, wl_q, c);
						wl_d = (wl_q != 4'd15) ? wl_q + 4'd1 : wl_q;
						res[nres] = mk_char(c);
						nres++;
						taken = 1'b1;
					end
				end
				dts_pkg::MODE_DIGITS: begin
					if (dts_pkg::is_digit(c)) begin
						res[nres] = mk_char(c);
						nres++;
						taken = 1'b1;
					end
				end
				dts_pkg::MODE_COLON: begin
					if (c == dts_pkg::CH_DASH) begin
						if (dash_q != 2'd2)
							dash_d = dash_q + 2'd1;
						res[nres] = mk_char(c);
						nres++;
						taken = 1'b1;
					end
				end
				dts_pkg::MODE_BSLASH: begin
					if (dts_pkg::is_letter(c) || c == dts_pkg::CH_DASH) begin
						res[nres] = mk_char(c);
						nres++;
						taken = 1'b1;
					end
				end
				default: ;
			endcase

			if (!taken) begin
				if (fin_emit) begin
					res[nres] = mk_tok(fin_kind, ln);
					nres++;
				end
				mode_d = dts_pkg::MODE_IDLE;
				unique case (c) inside
					dts_pkg::CH_SPACE, dts_pkg::CH_TAB: ;
					dts_pkg::CH_HASH: mode_d = dts_pkg::MODE_COMMENT;
					dts_pkg::CH_COMMA, dts_pkg::CH_PERIOD, dts_pkg::CH_QMARK,
					dts_pkg::CH_LPAREN, dts_pkg::CH_RPAREN: begin
						res[nres] = mk_char(c);
						nres++;
						res[nres] = mk_tok(dts_pkg::punct_kind(c), ln);
						nres++;
					end
					dts_pkg::CH_COLON: begin
						res[nres] = mk_char(c);
						nres++;
						dash_d = 2'd0;
						mode_d = dts_pkg::MODE_COLON;
					end
					dts_pkg::CH_QUOTE: mode_d = dts_pkg::MODE_STRING;
					dts_pkg::CH_BSLASH: begin
						res[nres] = mk_char(c);
						nres++;
						mode_d = dts_pkg::MODE_BSLASH;
					end
					default: begin
						res[nres] = mk_char(c);
						nres++;
						if (dts_pkg::is_letter(c)) begin
							alive_d = dts_pkg::kw_match(4'hF, 4'd0, c);
							wl_d    = 4'd1;
							mode_d  = dts_pkg::MODE_WORD;
						end else if (dts_pkg::is_digit(c)) begin
							mode_d = dts_pkg::MODE_DIGITS;
						end else begin
							res[nres] = mk_tok(dts_pkg::TK_ERROR, ln);
							nres++;
						end
					end
				endcase
			end
		end

		if (nres != 2'd0)
			res[nres - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= dts_pkg::MODE_IDLE;
			alive_q <= 4'hF;
			wl_q    <= 4'd0;
			dash_q  <= 2'd0;
			line_q  <= '0;
			open_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			alive_q <= alive_d;
			wl_q    <= wl_d;
			dash_q  <= dash_d;
			line_q  <= line_d;
			open_q  <= open_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (accept)
				wr_q <= wr_q + nres;
			if (pop)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q - {2'd0, pop} + (accept ? {1'b0, nres} : 3'd0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < dts_pkg::MAX_RESULTS; i++) begin
			if (accept && 2'(i) < nres)
				fifo_q[wr_q + 2'(i)] <= res[i];
		end
	end

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(dts_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.record_kind == dts_pkg::REC_CHAR
		|-> res_item.token_kind == dts_pkg::TK_COMMA && res_item.line_number == 16'd0)
		else $error("character record carries token fields");

	a_token_line: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.record_kind == dts_pkg::REC_TOKEN
		&& res_item.token_kind != dts_pkg::TK_ENDFILE
		|-> res_item.line_number != 16'd0)
		else $error("token reported on line zero");

	a_eof_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_item.operation == dts_pkg::OP_EOF
		|=> line_q == '0 && mode_q == dts_pkg::MODE_IDLE && !open_q)
		else $error("end of file did not restore scanner state");

	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_item.operation == dts_pkg::OP_EOF |=> cnt_q != 3'd0)
		else $error("end of file produced no record");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 16;
	localparam int PHASE_ITEMS = 102;

	// Lexer state mirror; every accepted request expands into its expected result records.
	class lexeme_board;
		dts_pkg::res_item_t expected_records[$];
		dts_pkg::res_item_t burst[$];
		int errors;
		dts_pkg::scan_mode_t mode;
		logic [3:0] kw_alive;
		logic [3:0] word_len;
		logic [1:0] dashes;
		logic [15:0] line_no;
		logic line_open;

		function new();
			errors = 0;
			clear_state();
		endfunction

		static function string keyword_text(int k);
			case (k)
				0: return "Schemes";
				1: return "Facts";
				2: return "Rules";
				default: return "Queries";
			endcase
		endfunction

		static function bit is_alpha(logic [7:0] c);
			return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd96 && c <= 8'd123);
		endfunction

		static function bit is_num(logic [7:0] c);
			return c >= 8'd48 && c <= 8'd57;
		endfunction

		function void clear_state();
			mode = dts_pkg::MODE_IDLE;
			kw_alive = 4'hF;
			word_len = 4'd0;
			dashes = 2'd0;
			line_no = 16'd0;
			line_open = 1'b0;
		endfunction

		function int pending();
			return expected_records.size();
		endfunction

		function void bump_line();
			if (line_no != 16'hFFFF)
				line_no++;
		endfunction

		function void put(logic kind, logic [7:0] c, dts_pkg::tok_kind_t tok);
			dts_pkg::res_item_t r;
			if (burst.size() >= dts_pkg::MAX_RESULTS)
				return;
			r.record_kind = kind;
			r.lexeme_char = (kind == dts_pkg::REC_TOKEN) ? 8'd0 : c;
			r.token_kind = (kind == dts_pkg::REC_TOKEN) ? tok : dts_pkg::TK_COMMA;
			r.line_number = (kind == dts_pkg::REC_TOKEN) ? line_no : 16'd0;
			r.last = 1'b0;
			burst = {burst, r};
		endfunction

		function void take_letter(logic [7:0] c);
			string w;
			for (int k = 0; k < 4; k++) begin
				w = keyword_text(k);
				if (word_len >= w.len() || w[word_len] != c)
					kw_alive[k] = 1'b0;
			end
			if (word_len != 4'd15)
				word_len++;
		endfunction

		function void close_token();
			dts_pkg::tok_kind_t tok;
			string w;
			case (mode)
				dts_pkg::MODE_WORD: begin
					tok = dts_pkg::TK_ID;
					for (int k = 0; k < 4; k++) begin
						w = keyword_text(k);
						if (kw_alive[k] && word_len == w.len())
							tok = dts_pkg::tok_kind_t'(int'(dts_pkg::TK_SCHEMES) + k);
					end
					put(dts_pkg::REC_TOKEN, 8'd0, tok);
				end
				dts_pkg::MODE_DIGITS, dts_pkg::MODE_STRING:
					put(dts_pkg::REC_TOKEN, 8'd0, dts_pkg::TK_ERROR);
				dts_pkg::MODE_COLON:
					put(dts_pkg::REC_TOKEN, 8'd0,
						(dashes == 2'd1) ? dts_pkg::TK_COLONDASH : dts_pkg::TK_COLON);
				dts_pkg::MODE_BSLASH: put(dts_pkg::REC_TOKEN, 8'd0, dts_pkg::TK_ID);
				default: ;
			endcase
			mode = dts_pkg::MODE_IDLE;
		endfunction

		function void open_token(logic [7:0] c);
			dts_pkg::tok_kind_t tok;
			case (c)
				dts_pkg::CH_SPACE, dts_pkg::CH_TAB: ;
				dts_pkg::CH_HASH: mode = dts_pkg::MODE_COMMENT;
				dts_pkg::CH_COMMA, dts_pkg::CH_PERIOD, dts_pkg::CH_QMARK,
				dts_pkg::CH_LPAREN, dts_pkg::CH_RPAREN: begin
					case (c)
						dts_pkg::CH_COMMA: tok = dts_pkg::TK_COMMA;
						dts_pkg::CH_PERIOD: tok = dts_pkg::TK_PERIOD;
						dts_pkg::CH_QMARK: tok = dts_pkg::TK_QMARK;
						dts_pkg::CH_LPAREN: tok = dts_pkg::TK_LPAREN;
						default: tok = dts_pkg::TK_RPAREN;
					endcase
					put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
					put(dts_pkg::REC_TOKEN, 8'd0, tok);
				end
				dts_pkg::CH_COLON: begin
					put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
					dashes = 2'd0;
					mode = dts_pkg::MODE_COLON;
				end
				dts_pkg::CH_QUOTE: mode = dts_pkg::MODE_STRING;
				dts_pkg::CH_BSLASH: begin
					put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
					mode = dts_pkg::MODE_BSLASH;
				end
				default: begin
					if (is_alpha(c)) begin
						kw_alive = 4'hF;
						word_len = 4'd0;
						take_letter(c);
						put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
						mode = dts_pkg::MODE_WORD;
					end else if (is_num(c)) begin
						put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
						mode = dts_pkg::MODE_DIGITS;
					end else begin
						put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
						put(dts_pkg::REC_TOKEN, 8'd0, dts_pkg::TK_ERROR);
					end
				end
			endcase
		endfunction

		function void note_byte(dts_pkg::src_item_t it);
			logic [7:0] c;
			bit taken;
			c = it.char_code;
			taken = 1'b0;
			burst.delete();
			if (it.operation == dts_pkg::OP_EOF) begin
				if (line_open)
					close_token();
				put(dts_pkg::REC_TOKEN, 8'd0, dts_pkg::TK_ENDFILE);
				clear_state();
			end else if (c == dts_pkg::CH_NEWLINE) begin
				// a newline on an empty line still counts a line
				if (!line_open)
					bump_line();
				close_token();
				line_open = 1'b0;
			end else begin
				if (!line_open) begin
					bump_line();
					line_open = 1'b1;
				end
				case (mode)
					dts_pkg::MODE_STRING: begin
						if (c == dts_pkg::CH_QUOTE) begin
							put(dts_pkg::REC_TOKEN, 8'd0, dts_pkg::TK_STRING);
							mode = dts_pkg::MODE_IDLE;
						end else begin
							put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
						end
						taken = 1'b1;
					end
					dts_pkg::MODE_COMMENT: taken = 1'b1;
					dts_pkg::MODE_WORD: begin
						if (is_alpha(c) || is_num(c)) begin
							take_letter(c);
							put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
							taken = 1'b1;
						end
					end
					dts_pkg::MODE_DIGITS: begin
						if (is_num(c)) begin
							put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
							taken = 1'b1;
						end
					end
					dts_pkg::MODE_COLON: begin
						if (c == dts_pkg::CH_DASH) begin
							if (dashes != 2'd2)
								dashes++;
							put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
							taken = 1'b1;
						end
					end
					dts_pkg::MODE_BSLASH: begin
						if (is_alpha(c) || c == dts_pkg::CH_DASH) begin
							put(dts_pkg::REC_CHAR, c, dts_pkg::TK_COMMA);
							taken = 1'b1;
						end
					end
					default: mode = dts_pkg::MODE_IDLE;
				endcase
				if (!taken) begin
					close_token();
					open_token(c);
				end
			end
			if (burst.size() > 0)
				burst[burst.size() - 1].last = 1'b1;
			expected_records = {expected_records, burst};
		endfunction

		function void check_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
			if (got_v !== want_v) begin
				$display("[%0t] %s mismatch: expected %0d, actual %0d", $time, fname,
					want_v, got_v);
				errors++;
			end
		endfunction

		function void check_record(dts_pkg::res_item_t got);
			dts_pkg::res_item_t want;
			if (expected_records.size() == 0) begin
				$display("[%0t] unexpected record: expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = expected_records.pop_front();
			check_field("record_kind", 16'(want.record_kind), 16'(got.record_kind));
			check_field("lexeme_char", 16'(want.lexeme_char), 16'(got.lexeme_char));
			check_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
			check_field("line_number", want.line_number, got.line_number);
			check_field("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	dts_pkg::src_item_t src_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	dts_pkg::res_item_t res_item;

	lexeme_board board;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent_count = 0;
	int quiet_cycles = 0;

	datalog_token_scanner u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_item(src_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready)
				board.check_record(res_item);
			if (src_valid && src_ready)
				board.note_byte(src_item);
			if ((res_valid && res_ready) || (src_valid && src_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// called on a falling edge, returns on the falling edge after acceptance
	task automatic send_item(input logic op, input logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item <= '{operation: op, char_code: c};
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(dts_pkg::OP_CHAR, s[i]);
	endtask

	task automatic drain_results();
		src_valid <= 1'b0;
		@(negedge clk);
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(53);
		return (r < 26) ? 8'(65 + r) : 8'(70 + r);
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(3) == 0)
			return 8'(48 + $urandom_range(9));
		return rand_letter();
	endfunction

	// any byte but newline, plus the quote when quote_ok
	function automatic logic [7:0] rand_body_byte(bit quote_ok);
		logic [7:0] c;
		if ($urandom_range(4) == 0)
			return dts_pkg::CH_HASH;
		do
			c = 8'($urandom_range(255));
		while (c == dts_pkg::CH_NEWLINE || (!quote_ok && c == dts_pkg::CH_QUOTE));
		return c;
	endfunction

	task automatic send_lexeme();
		int r;
		int n;
		string w;
		r = $urandom_range(99);
		if (r < 12) begin
			w = lexeme_board::keyword_text($urandom_range(3));
			n = $urandom_range(3);
			if (n == 0)
				w = w.substr(0, $urandom_range(w.len() - 2));
			send_text(w);
			if (n == 1)
				send_item(dts_pkg::OP_CHAR, rand_alnum());
		end else if (r < 30) begin
			send_item(dts_pkg::OP_CHAR, rand_letter());
			// long names push the word length into saturation
			repeat ($urandom_range(17))
				send_item(dts_pkg::OP_CHAR, rand_alnum());
		end else if (r < 36) begin
			repeat ($urandom_range(4, 1))
				send_item(dts_pkg::OP_CHAR, 8'(48 + $urandom_range(9)));
		end else if (r < 48) begin
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_QUOTE);
			repeat ($urandom_range(6))
				send_item(dts_pkg::OP_CHAR, rand_body_byte(1'b0));
			if ($urandom_range(3) != 0)
				send_item(dts_pkg::OP_CHAR, dts_pkg::CH_QUOTE);
		end else if (r < 54) begin
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_BSLASH);
			repeat ($urandom_range(4))
				send_item(dts_pkg::OP_CHAR,
					($urandom_range(2) == 0) ? dts_pkg::CH_DASH : rand_letter());
		end else if (r < 62) begin
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_COLON);
			repeat ($urandom_range(3))
				send_item(dts_pkg::OP_CHAR, dts_pkg::CH_DASH);
		end else if (r < 78) begin
			case ($urandom_range(4))
				0: send_item(dts_pkg::OP_CHAR, dts_pkg::CH_COMMA);
				1: send_item(dts_pkg::OP_CHAR, dts_pkg::CH_PERIOD);
				2: send_item(dts_pkg::OP_CHAR, dts_pkg::CH_QMARK);
				3: send_item(dts_pkg::OP_CHAR, dts_pkg::CH_LPAREN);
				default: send_item(dts_pkg::OP_CHAR, dts_pkg::CH_RPAREN);
			endcase
		end else if (r < 82) begin
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_HASH);
			repeat ($urandom_range(5))
				send_item(dts_pkg::OP_CHAR, rand_body_byte(1'b1));
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_NEWLINE);
		end else if (r < 86) begin
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_DASH);
		end else if (r < 95) begin
			send_item(dts_pkg::OP_CHAR, 8'($urandom_range(255)));
		end else if (r < 97) begin
			send_item(dts_pkg::OP_EOF, 8'($urandom_range(255)));
		end else begin
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_NEWLINE);
		end
		n = $urandom_range(9);
		if (n < 4)
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_SPACE);
		else if (n == 4)
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_TAB);
		else if (n == 5)
			send_item(dts_pkg::OP_CHAR, dts_pkg::CH_NEWLINE);
	endtask

	initial begin
		int phase_start;
		board = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// keyword, colon-dash vs colon with two dashes, '#' inside a string
		send_text("Facts:-:--'#'\n");
		// lone dash, digits, bytes of no class, string cut by newline
		send_text("-9");
		send_item(dts_pkg::OP_CHAR, 8'h00);
		send_item(dts_pkg::OP_CHAR, 8'hFF);
		send_text("'\n");
		// string still open at end of file
		send_text("'x");
		send_item(dts_pkg::OP_EOF, 8'hFF);
		send_text("\n");
		send_item(dts_pkg::OP_EOF, 8'h00);
		drain_results();

		send_text("ab\nc");
		send_item(dts_pkg::OP_EOF, 8'h5A);
		drain_results();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 79; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 79; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			phase_start = sent_count;
			while (sent_count - phase_start < PHASE_ITEMS)
				send_lexeme();
			drain_results();
		end

		idle_pct = 0;
		stall_pct = 0;
		send_item(dts_pkg::OP_EOF, 8'h00);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
hdl/dts_pkg.sv
hdl/datalog_token_scanner.sv
dv/tb.sv
